// File: rtl/dnsax_pkg.sv
// Shared types, codes and helpers of the DNS answer record extractor.
package dnsax_pkg;

  // Parse phases, one-hot.
  typedef enum logic [9:0] {
    PH_HEADER = 10'b00_0000_0001,
    PH_QNAME  = 10'b00_0000_0010,
    PH_QPTR   = 10'b00_0000_0100,
    PH_QTAIL  = 10'b00_0000_1000,
    PH_ANAME  = 10'b00_0001_0000,
    PH_APTR   = 10'b00_0010_0000,
    PH_AFIX   = 10'b00_0100_0000,
    PH_DATA   = 10'b00_1000_0000,
    PH_DONE   = 10'b01_0000_0000,
    PH_SKIP   = 10'b10_0000_0000
  } phase_e;

  // Result kinds.
  localparam logic [1:0] RES_ANSWER_HDR = 2'd0;
  localparam logic [1:0] RES_DATA_BYTE  = 2'd1;
  localparam logic [1:0] RES_IGNORED    = 2'd2;
  localparam logic [1:0] RES_TRUNCATED  = 2'd3;

  // Record kinds.
  localparam logic [1:0] REC_ADDRESS = 2'd0;
  localparam logic [1:0] REC_NAME    = 2'd1;
  localparam logic [1:0] REC_TEXT    = 2'd2;
  localparam logic [1:0] REC_OTHER   = 2'd3;

  // Answer type codes.
  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [15:0] TYPE_CNAME = 16'd5;
  localparam logic [15:0] TYPE_PTR   = 16'd12;
  localparam logic [15:0] TYPE_TXT   = 16'd16;

  // Last byte indices of the header and of the fixed fields, counted from zero.
  localparam logic [3:0] HDR_LAST_IDX   = 4'd11;
  localparam logic [3:0] QTAIL_LAST_IDX = 4'd3;
  localparam logic [3:0] AFIX_LAST_IDX  = 4'd9;

  // One result as it travels from parser to output stage.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] record_type;
    logic [15:0] record_class_value;
    logic [31:0] time_to_live;
    logic [15:0] data_length;
    logic [7:0]  data_byte;
    logic        final_res;
  } res_t;

  function automatic logic [1:0] record_kind_of(input logic [15:0] rtype);
    logic [1:0] rk;
    rk = REC_OTHER;
    if (rtype == TYPE_A) begin
      rk = REC_ADDRESS;
    end else if (rtype == TYPE_CNAME || rtype == TYPE_PTR) begin
      rk = REC_NAME;
    end else if (rtype == TYPE_TXT) begin
      rk = REC_TEXT;
    end
    return rk;
  endfunction

endpackage

// File: rtl/dns_answer_record_extractor_top.sv
// DNS answer record extractor:
// Slave stream takes a DNS response one byte per transaction (tdata = byte,
// tlast = final byte of the message). The parser checks the header id against
// the value written on the configuration port, walks question and answer
// names, and emits one result for the answer header and one per rdata byte,
// plus an ignored or truncated marker on the final byte where that applies.
// Master stream carries results; tlast marks the last result of a message.
// A write on cfg_wr_en_i/cfg_wr_data_i sets the expected id and reopens the
// query; write only while no message is in flight.
// Throughput: one byte per cycle while the result queue is not full.
// Each result is written into the queue and then into the output register.
// A FIFO_DEPTH-entry result queue plus the output register decouple the
// sides: when the receiver stalls, bytes are still taken until the queue
// fills, then s_axis_tready_o drops. Reset clears the parser, empties the
// queue and sets the expected id to zero (all responses ignored).
module dns_answer_record_extractor_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // msg_byte
  input  logic        s_axis_tlast_i,   // msg_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // record_type [15:0], record_class_value [31:16], time_to_live [63:32],
  // data_length [79:64], data_byte [87:80]
  output logic [87:0] m_axis_tdata_o,
  output logic [3:0]  m_axis_tuser_o,   // result_kind [1:0], record_kind [3:2]
  output logic        m_axis_tlast_o    // final_res
);
  import dnsax_pkg::*;

  logic full, empty, pop, res_vld, accept;
  res_t res, head;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  dnsax_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .byte_vld_i   (accept),
    .byte_i       (s_axis_tdata_i),
    .last_i       (s_axis_tlast_i),
    .res_vld_o    (res_vld),
    .res_o        (res)
  );

  dnsax_fifo #(
    .Depth(FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_vld),
    .push_data_i(res),
    .pop_i      (pop),
    .pop_data_o (head),
    .full_o     (full),
    .empty_o    (empty)
  );

  dnsax_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (empty),
    .q_data_i       (head),
    .q_pop_o        (pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

// File: rtl/dnsax_parser.sv
// Front end: byte-wise message parser that classifies bytes and builds results.
module dnsax_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [15:0]       cfg_wr_data_i,
  input  logic              byte_vld_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output logic              res_vld_o,
  output dnsax_pkg::res_t   res_o
);
  import dnsax_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [7:0]  lbl_q, lbl_d;
  logic [15:0] id_q, id_d;
  logic [15:0] type_q, type_d;
  logic [15:0] class_q, class_d;
  logic [31:0] ttl_q, ttl_d;
  logic [15:0] len_q, len_d;
  logic [15:0] left_q, left_d;
  logic        qopen_q, qopen_d;
  logic [15:0] exp_id_q;
  logic [15:0] id_full;

  assign id_full = {id_q[15:8], byte_i};

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    lbl_d     = lbl_q;
    id_d      = id_q;
    type_d    = type_q;
    class_d   = class_q;
    ttl_d     = ttl_q;
    len_d     = len_q;
    left_d    = left_q;
    qopen_d   = qopen_q;
    res_vld_o = 1'b0;
    res_o     = '0;

    if (byte_vld_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (cnt_q == 4'd0) begin
            id_d = {byte_i, 8'h00};
          end else if (cnt_q == 4'd1) begin
            id_d = id_full;
            if (qopen_q && exp_id_q != 16'd0 && id_full == exp_id_q) begin
              qopen_d = 1'b0;
            end else begin
              phase_d = PH_SKIP;
            end
          end
          if (phase_d == PH_HEADER) begin
            cnt_d = cnt_q + 4'd1;
            if (cnt_q == HDR_LAST_IDX) begin
              phase_d = PH_QNAME;
              cnt_d   = '0;
              lbl_d   = '0;
            end
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (lbl_q != 8'd0) begin
            lbl_d = lbl_q - 8'd1;
          end else if (byte_i[7:6] != 2'b00) begin
            phase_d = (phase_q == PH_QNAME) ? PH_QPTR : PH_APTR;
          end else if (byte_i == 8'd0) begin
            phase_d = (phase_q == PH_QNAME) ? PH_QTAIL : PH_AFIX;
            cnt_d   = '0;
          end else begin
            lbl_d = byte_i;
          end
        end
        PH_QPTR: begin
          phase_d = PH_QTAIL;
          cnt_d   = '0;
        end
        PH_QTAIL: begin
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == QTAIL_LAST_IDX) begin
            phase_d = PH_ANAME;
            cnt_d   = '0;
            lbl_d   = '0;
          end
        end
        PH_APTR: begin
          phase_d = PH_AFIX;
          cnt_d   = '0;
        end
        PH_AFIX: begin
          if (cnt_q < 4'd2) begin
            type_d = {type_q[7:0], byte_i};
          end else if (cnt_q < 4'd4) begin
            class_d = {class_q[7:0], byte_i};
          end else if (cnt_q < 4'd8) begin
            ttl_d = {ttl_q[23:0], byte_i};
          end else begin
            len_d = {len_q[7:0], byte_i};
          end
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == AFIX_LAST_IDX) begin
            cnt_d                    = '0;
            left_d                   = len_d;
            res_vld_o                = 1'b1;
            res_o.result_kind        = RES_ANSWER_HDR;
            res_o.record_type        = type_d;
            res_o.record_class_value = class_d;
            res_o.time_to_live       = ttl_d;
            res_o.data_length        = len_d;
            res_o.final_res          = (len_d == 16'd0);
            phase_d                  = (len_d == 16'd0) ? PH_DONE : PH_DATA;
          end
        end
        PH_DATA: begin
          left_d                   = left_q - 16'd1;
          res_vld_o                = 1'b1;
          res_o.result_kind        = RES_DATA_BYTE;
          res_o.record_type        = type_q;
          res_o.record_class_value = class_q;
          res_o.time_to_live       = ttl_q;
          res_o.data_length        = len_q;
          res_o.data_byte          = byte_i;
          res_o.final_res          = (left_d == 16'd0);
          if (left_d == 16'd0) begin
            phase_d = PH_DONE;
          end
        end
        PH_DONE, PH_SKIP: begin
        end
        default: begin
        end
      endcase

      // End of message: report ignored or cut-short messages, then restart.
      if (last_i) begin
        if (phase_d != PH_DONE) begin
          res_vld_o         = 1'b1;
          res_o             = '0;
          res_o.result_kind = (phase_d == PH_SKIP) ? RES_IGNORED : RES_TRUNCATED;
          res_o.final_res   = 1'b1;
        end
        phase_d = PH_HEADER;
        cnt_d   = '0;
        lbl_d   = '0;
        id_d    = '0;
        type_d  = '0;
        class_d = '0;
        ttl_d   = '0;
        len_d   = '0;
        left_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      cnt_q    <= '0;
      lbl_q    <= '0;
      id_q     <= '0;
      type_q   <= '0;
      class_q  <= '0;
      ttl_q    <= '0;
      len_q    <= '0;
      left_q   <= '0;
      qopen_q  <= 1'b1;
      exp_id_q <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      lbl_q   <= lbl_d;
      id_q    <= id_d;
      type_q  <= type_d;
      class_q <= class_d;
      ttl_q   <= ttl_d;
      len_q   <= len_d;
      left_q  <= left_d;
      // A register write reopens the query.
      if (cfg_wr_en_i) begin
        exp_id_q <= cfg_wr_data_i;
        qopen_q  <= 1'b1;
      end else begin
        qopen_q <= qopen_d;
      end
    end
  end

endmodule

// File: rtl/dnsax_fifo.sv
// Short result queue between parser and output stage.
module dnsax_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dnsax_pkg::res_t push_data_i,
  input  logic            pop_i,
  output dnsax_pkg::res_t pop_data_o,
  output logic            full_o,
  output logic            empty_o
);
  import dnsax_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == DepthCnt);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/dnsax_out.sv
// Back end: output register that classifies the record and drives the stream.
module dnsax_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  dnsax_pkg::res_t q_data_i,
  output logic            q_pop_o,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [87:0]     m_axis_tdata_o,
  output logic [3:0]      m_axis_tuser_o,
  output logic            m_axis_tlast_o
);
  import dnsax_pkg::*;

  logic        vld_q;
  logic [87:0] data_q;
  logic [3:0]  user_q;
  logic        last_q;
  logic [1:0]  rec_kind;
  logic        load;

  // Load whenever the queue holds a result and the register is empty or its transaction completes.
  assign load    = !q_empty_i && (!vld_q || m_axis_tready_i);
  assign q_pop_o = load;

  always_comb begin
    rec_kind = REC_ADDRESS;
    if (q_data_i.result_kind == RES_ANSWER_HDR || q_data_i.result_kind == RES_DATA_BYTE) begin
      rec_kind = record_kind_of(q_data_i.record_type);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= {q_data_i.data_byte, q_data_i.data_length, q_data_i.time_to_live,
                 q_data_i.record_class_value, q_data_i.record_type};
      user_q <= {rec_kind, q_data_i.result_kind};
      last_q <= q_data_i.final_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      vld_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = user_q;
  assign m_axis_tlast_o  = last_q;

endmodule
